// ===== design/capsule_sphere_collision_test_core_assert.svh =====
// Assertion macros for the capsule/sphere test core.
`ifndef CAPSULE_SPHERE_COLLISION_TEST_CORE_ASSERT_SVH
`define CAPSULE_SPHERE_COLLISION_TEST_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CSCT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csct: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CSCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csct: next-cycle check failed");

`endif

// ===== design/csct_pkg.sv =====
`timescale 1ns / 1ps

package csct_pkg;

    localparam int W_COORD = 32;   // Q16.16 coordinate
    localparam int W_RAD   = 31;   // unsigned Q15.16 radius
    localparam int W_DIFF  = 33;   // coordinate difference
    localparam int W_SQ    = 66;   // product of two differences
    localparam int W_DOT   = 68;   // sum of three products
    localparam int W_HALF  = 34;   // half of a dot-product operand
    localparam int W_PP    = 68;   // partial product of two halves
    localparam int W_PROD  = 136;  // full product of two dot results
    localparam int W_RSUM  = 32;   // sum of the two radii
    localparam int W_R2    = 64;   // squared radius sum
    localparam int W_ADDR  = 5;
    localparam int W_DATA  = 32;
    localparam int W_IDX   = 3;
    localparam int N_STAGE = 6;

    typedef enum logic [W_IDX-1:0] {
        REG_SEG_A_X,
        REG_SEG_A_Y,
        REG_SEG_A_Z,
        REG_SEG_B_X,
        REG_SEG_B_Y,
        REG_SEG_B_Z,
        REG_CAPSULE_RADIUS
    } t_reg_idx;

    typedef struct packed {
        logic signed [W_COORD-1:0] a_x;
        logic signed [W_COORD-1:0] a_y;
        logic signed [W_COORD-1:0] a_z;
        logic signed [W_COORD-1:0] b_x;
        logic signed [W_COORD-1:0] b_y;
        logic signed [W_COORD-1:0] b_z;
        logic        [W_RAD-1:0]   radius;
    } t_capsule;

    // Load enables, one per pipeline stage; stage 1 sits in bit 0
    typedef struct packed {
        logic s6;
        logic s5;
        logic s4;
        logic s3;
        logic s2;
        logic s1;
    } t_pipe_en;

    // Region decision carried alongside the wide products
    typedef struct packed {
        logic act;
        logic near_a;
        logic near_b;
        logic hit_a;
        logic hit_b;
    } t_sel;

endpackage

// ===== design/csct_regs.sv =====
`timescale 1ns / 1ps

module csct_regs
    import csct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [W_ADDR-1:0] paddr,
    input  logic [W_DATA-1:0] pwdata,
    output logic [W_DATA-1:0] prdata,
    output logic              pready,
    output t_capsule          o_capsule
);

    t_capsule r_cap;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[W_ADDR-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SEG_A_X:        r_cap.a_x    <= $signed(pwdata);
                REG_SEG_A_Y:        r_cap.a_y    <= $signed(pwdata);
                REG_SEG_A_Z:        r_cap.a_z    <= $signed(pwdata);
                REG_SEG_B_X:        r_cap.b_x    <= $signed(pwdata);
                REG_SEG_B_Y:        r_cap.b_y    <= $signed(pwdata);
                REG_SEG_B_Z:        r_cap.b_z    <= $signed(pwdata);
                REG_CAPSULE_RADIUS: r_cap.radius <= pwdata[W_RAD-1:0];
                default:            r_cap        <= r_cap;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SEG_A_X:        prdata = r_cap.a_x;
            REG_SEG_A_Y:        prdata = r_cap.a_y;
            REG_SEG_A_Z:        prdata = r_cap.a_z;
            REG_SEG_B_X:        prdata = r_cap.b_x;
            REG_SEG_B_Y:        prdata = r_cap.b_y;
            REG_SEG_B_Z:        prdata = r_cap.b_z;
            REG_CAPSULE_RADIUS: prdata = {1'b0, r_cap.radius};
            default:            prdata = '0;
        endcase
    end

    assign o_capsule = r_cap;

endmodule

// ===== design/csct_dot.sv =====
`timescale 1ns / 1ps

// Stages 1-3: differences, per-axis products, then the dot sums.
module csct_dot
    import csct_pkg::*;
(
    input  logic                      i_clk,
    input  t_pipe_en                  i_en,
    input  t_capsule                  i_capsule,
    input  logic signed [W_COORD-1:0] i_px,
    input  logic signed [W_COORD-1:0] i_py,
    input  logic signed [W_COORD-1:0] i_pz,
    input  logic        [W_RAD-1:0]   i_prad,
    input  logic                      i_pact,
    output logic        [W_DOT-1:0]   o_ab2,
    output logic signed [W_DOT-1:0]   o_d,
    output logic        [W_DOT-1:0]   o_ap2,
    output logic        [W_DOT-1:0]   o_bp2,
    output logic        [W_R2-1:0]    o_r2,
    output logic                      o_act
);

    logic signed [W_DIFF-1:0] w_a [3];
    logic signed [W_DIFF-1:0] w_b [3];
    logic signed [W_DIFF-1:0] w_p [3];

    logic signed [W_DIFF-1:0] r_ab [3];
    logic signed [W_DIFF-1:0] r_ap [3];
    logic signed [W_DIFF-1:0] r_bp [3];
    logic        [W_RSUM-1:0] r_rsum;
    logic                     r_act1;

    logic signed [W_SQ-1:0]   r_ab_sq [3];
    logic signed [W_SQ-1:0]   r_apab  [3];
    logic signed [W_SQ-1:0]   r_ap_sq [3];
    logic signed [W_SQ-1:0]   r_bp_sq [3];
    logic        [W_R2-1:0]   r_r2_2;
    logic                     r_act2;

    logic signed [W_DOT-1:0]  n_ab2;
    logic signed [W_DOT-1:0]  n_d;
    logic signed [W_DOT-1:0]  n_ap2;
    logic signed [W_DOT-1:0]  n_bp2;
    logic        [W_DOT-1:0]  r_ab2;
    logic signed [W_DOT-1:0]  r_d;
    logic        [W_DOT-1:0]  r_ap2;
    logic        [W_DOT-1:0]  r_bp2;
    logic        [W_R2-1:0]   r_r2_3;
    logic                     r_act3;

    assign w_a[0] = {i_capsule.a_x[W_COORD-1], i_capsule.a_x};
    assign w_a[1] = {i_capsule.a_y[W_COORD-1], i_capsule.a_y};
    assign w_a[2] = {i_capsule.a_z[W_COORD-1], i_capsule.a_z};
    assign w_b[0] = {i_capsule.b_x[W_COORD-1], i_capsule.b_x};
    assign w_b[1] = {i_capsule.b_y[W_COORD-1], i_capsule.b_y};
    assign w_b[2] = {i_capsule.b_z[W_COORD-1], i_capsule.b_z};
    assign w_p[0] = {i_px[W_COORD-1], i_px};
    assign w_p[1] = {i_py[W_COORD-1], i_py};
    assign w_p[2] = {i_pz[W_COORD-1], i_pz};

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int i = 0; i < 3; i++) begin
                r_ab[i] <= w_b[i] - w_a[i];
                r_ap[i] <= w_p[i] - w_a[i];
                r_bp[i] <= w_p[i] - w_b[i];
            end
            r_rsum <= {1'b0, i_capsule.radius} + {1'b0, i_prad};
            r_act1 <= i_pact;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int i = 0; i < 3; i++) begin
                r_ab_sq[i] <= r_ab[i] * r_ab[i];
                r_apab[i]  <= r_ap[i] * r_ab[i];
                r_ap_sq[i] <= r_ap[i] * r_ap[i];
                r_bp_sq[i] <= r_bp[i] * r_bp[i];
            end
            r_r2_2 <= r_rsum * r_rsum;
            r_act2 <= r_act1;
        end
    end

    always_comb begin
        n_ab2 = '0;
        n_d   = '0;
        n_ap2 = '0;
        n_bp2 = '0;
        for (int i = 0; i < 3; i++) begin
            n_ab2 = n_ab2 + {{(W_DOT-W_SQ){r_ab_sq[i][W_SQ-1]}}, r_ab_sq[i]};
            n_d   = n_d   + {{(W_DOT-W_SQ){r_apab[i][W_SQ-1]}},  r_apab[i]};
            n_ap2 = n_ap2 + {{(W_DOT-W_SQ){r_ap_sq[i][W_SQ-1]}}, r_ap_sq[i]};
            n_bp2 = n_bp2 + {{(W_DOT-W_SQ){r_bp_sq[i][W_SQ-1]}}, r_bp_sq[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_ab2  <= $unsigned(n_ab2);
            r_d    <= n_d;
            r_ap2  <= $unsigned(n_ap2);
            r_bp2  <= $unsigned(n_bp2);
            r_r2_3 <= r_r2_2;
            r_act3 <= r_act2;
        end
    end

    assign o_ab2 = r_ab2;
    assign o_d   = r_d;
    assign o_ap2 = r_ap2;
    assign o_bp2 = r_bp2;
    assign o_r2  = r_r2_3;
    assign o_act = r_act3;

endmodule

// ===== design/csct_wmul.sv =====
`timescale 1ns / 1ps

// Stages 4-5: 68x68 unsigned product from four 34x34 partial products.
module csct_wmul
    import csct_pkg::*;
(
    input  logic              i_clk,
    input  t_pipe_en          i_en,
    input  logic [W_DOT-1:0]  i_a,
    input  logic [W_DOT-1:0]  i_b,
    output logic [W_PROD-1:0] o_p
);

    logic [W_HALF-1:0] w_a_lo;
    logic [W_HALF-1:0] w_a_hi;
    logic [W_HALF-1:0] w_b_lo;
    logic [W_HALF-1:0] w_b_hi;
    logic [W_PP-1:0]   r_pp00;
    logic [W_PP-1:0]   r_pp01;
    logic [W_PP-1:0]   r_pp10;
    logic [W_PP-1:0]   r_pp11;
    logic [W_PP:0]     w_mid;
    logic [W_PROD-1:0] n_p;
    logic [W_PROD-1:0] r_p;

    assign w_a_lo = i_a[W_HALF-1:0];
    assign w_a_hi = i_a[W_DOT-1:W_HALF];
    assign w_b_lo = i_b[W_HALF-1:0];
    assign w_b_hi = i_b[W_DOT-1:W_HALF];

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_pp00 <= w_a_lo * w_b_lo;
            r_pp01 <= w_a_lo * w_b_hi;
            r_pp10 <= w_a_hi * w_b_lo;
            r_pp11 <= w_a_hi * w_b_hi;
        end
    end

    // low and high partial products abut exactly, so they concatenate
    assign w_mid = {1'b0, r_pp01} + {1'b0, r_pp10};
    assign n_p   = {r_pp11, r_pp00} + W_PROD'({w_mid, {W_HALF{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== design/capsule_sphere_collision_test_core.sv =====
// Capsule versus sphere hit test, one sphere per transaction.
// Six register stages lie between input acceptance and o_out_valid.
// Throughput: one transaction per cycle while the output is not stalled.
// A stalled output holds every full stage behind it up to the first bubble; bubbles further up still close.
// Reset (i_rst_n low, synchronous) empties the pipeline and zeroes all capsule registers.
`timescale 1ns / 1ps
`include "capsule_sphere_collision_test_core_assert.svh"

module capsule_sphere_collision_test_core
    import csct_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [W_ADDR-1:0]         paddr,
    input  logic [W_DATA-1:0]         pwdata,
    output logic [W_DATA-1:0]         prdata,
    output logic                      pready,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic signed [W_COORD-1:0] i_sphere_x,
    input  logic signed [W_COORD-1:0] i_sphere_y,
    input  logic signed [W_COORD-1:0] i_sphere_z,
    input  logic        [W_RAD-1:0]   i_sphere_radius,
    input  logic                      i_sphere_active,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_hit
);

    t_capsule w_capsule;

    logic [N_STAGE-1:0] r_v;
    logic [N_STAGE-1:0] w_en;
    t_pipe_en           w_pen;

    logic        [W_DOT-1:0] w_ab2;
    logic signed [W_DOT-1:0] w_d;
    logic        [W_DOT-1:0] w_ap2;
    logic        [W_DOT-1:0] w_bp2;
    logic        [W_R2-1:0]  w_r2;
    logic                    w_act;
    logic        [W_DOT-1:0] w_r2_ext;

    logic [W_PROD-1:0] w_p_apab;
    logic [W_PROD-1:0] w_p_dd;
    logic [W_PROD-1:0] w_p_rab;
    logic [W_PROD-1:0] w_lhs;

    t_sel n_sel4;
    t_sel r_sel4;
    t_sel r_sel5;
    logic n_hit;
    logic r_hit;

    csct_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_capsule (w_capsule)
    );

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        w_en[N_STAGE-1] = !r_v[N_STAGE-1] || !i_out_stall;
        for (int k = N_STAGE - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_pen = t_pipe_en'(w_en[0 +: N_STAGE]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < N_STAGE; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_v[N_STAGE-1];

    csct_dot u_dot (
        .i_clk     (i_clk),
        .i_en      (w_pen),
        .i_capsule (w_capsule),
        .i_px      (i_sphere_x),
        .i_py      (i_sphere_y),
        .i_pz      (i_sphere_z),
        .i_prad    (i_sphere_radius),
        .i_pact    (i_sphere_active),
        .o_ab2     (w_ab2),
        .o_d       (w_d),
        .o_ap2     (w_ap2),
        .o_bp2     (w_bp2),
        .o_r2      (w_r2),
        .o_act     (w_act)
    );

    assign w_r2_ext = {{(W_DOT-W_R2){1'b0}}, w_r2};

    // |AP|^2 * |AB|^2
    csct_wmul u_mul_apab (
        .i_clk (i_clk),
        .i_en  (w_pen),
        .i_a   (w_ap2),
        .i_b   (w_ab2),
        .o_p   (w_p_apab)
    );

    // (AP.AB)^2; only used between the endpoints, where AP.AB is positive
    csct_wmul u_mul_dd (
        .i_clk (i_clk),
        .i_en  (w_pen),
        .i_a   ($unsigned(w_d)),
        .i_b   ($unsigned(w_d)),
        .o_p   (w_p_dd)
    );

    // (r_capsule + r_sphere)^2 * |AB|^2
    csct_wmul u_mul_rab (
        .i_clk (i_clk),
        .i_en  (w_pen),
        .i_a   (w_r2_ext),
        .i_b   (w_ab2),
        .o_p   (w_p_rab)
    );

    // Region of the closest point; a zero-length segment lands on endpoint A.
    always_comb begin
        n_sel4.act    = w_act;
        n_sel4.near_a = w_d[W_DOT-1] || (w_d == '0);
        n_sel4.near_b = $signed(w_ab2) <= w_d;
        n_sel4.hit_a  = w_ap2 <= w_r2_ext;
        n_sel4.hit_b  = w_bp2 <= w_r2_ext;
    end

    always_ff @(posedge i_clk) begin
        if (w_pen.s4) begin
            r_sel4 <= n_sel4;
        end
        if (w_pen.s5) begin
            r_sel5 <= r_sel4;
        end
    end

    assign w_lhs = w_p_apab - w_p_dd;

    always_comb begin
        priority if (r_sel5.near_a) begin
            n_hit = r_sel5.hit_a;
        end else if (r_sel5.near_b) begin
            n_hit = r_sel5.hit_b;
        end else begin
            n_hit = w_lhs <= w_p_rab;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pen.s6) begin
            r_hit <= r_sel5.act && n_hit;
        end
    end

    assign o_hit = r_hit;

    `CSCT_ASSERT_SAME(a_empty_front_takes, i_clk, i_rst_n, !r_v[0], !o_in_stall)
    `CSCT_ASSERT_SAME(a_stall_needs_block, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `CSCT_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_v[0])

endmodule

// ===== tb/sv/capsule_sphere_collision_test_core_test.sv =====
`timescale 1ns / 1ps

module capsule_sphere_collision_test_core_test;
    import csct_pkg::*;

    localparam int     N_REGS       = REG_CAPSULE_RADIUS + 1;
    localparam int     UNMAPPED_REG = N_REGS;   // first address with no register behind it
    localparam longint ONE          = 64'sd65536;   // 1.0 in Q16.16
    localparam longint C_MAX        = 64'sd2147483647;
    localparam longint C_MIN        = -64'sd2147483648;
    localparam longint R_MAX        = 64'sd2147483647;

    // wide enough for |AP|^2 * |AB|^2 (under 2^136) with sign
    typedef logic signed [159:0] t_wide;

    typedef struct packed {
        logic signed [W_COORD-1:0] x;
        logic signed [W_COORD-1:0] y;
        logic signed [W_COORD-1:0] z;
        logic        [W_RAD-1:0]   radius;
        logic                      active;
    } t_sphere;

    class sphere_hit_checker;
        t_capsule cap;
        bit       hits_due[$];
        int       failures;

        function new();
            cap      = '0;
            failures = 0;
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10)
                $display("mismatch: %s", msg);
        endfunction

        function void set_reg(int idx, logic [W_DATA-1:0] v);
            case (idx)
                REG_SEG_A_X:        cap.a_x = v;
                REG_SEG_A_Y:        cap.a_y = v;
                REG_SEG_A_Z:        cap.a_z = v;
                REG_SEG_B_X:        cap.b_x = v;
                REG_SEG_B_Y:        cap.b_y = v;
                REG_SEG_B_Z:        cap.b_z = v;
                REG_CAPSULE_RADIUS: cap.radius = v[W_RAD-1:0];
                default:            ;
            endcase
        endfunction

        function logic [W_DATA-1:0] reg_value(int idx);
            case (idx)
                REG_SEG_A_X:        return cap.a_x;
                REG_SEG_A_Y:        return cap.a_y;
                REG_SEG_A_Z:        return cap.a_z;
                REG_SEG_B_X:        return cap.b_x;
                REG_SEG_B_Y:        return cap.b_y;
                REG_SEG_B_Z:        return cap.b_z;
                REG_CAPSULE_RADIUS: return {1'b0, cap.radius};
                default:            return '0;
            endcase
        endfunction

        function void check_reg(int idx, logic [W_DATA-1:0] got);
            if (got !== reg_value(idx))
                flag($sformatf("register %0d read back: expected %h, actual %h",
                               idx, reg_value(idx), got));
        endfunction

        // Exact test on squared distances, clamped projection onto AB.
        function bit predict_hit(t_sphere s);
            t_wide abx, aby, abz, apx, apy, apz, bpx, bpy, bpz;
            t_wide ab2, d, ap2, bp2, rsum, r2;
            if (!s.active)
                return 1'b0;
            abx  = t_wide'($signed(cap.b_x)) - t_wide'($signed(cap.a_x));
            aby  = t_wide'($signed(cap.b_y)) - t_wide'($signed(cap.a_y));
            abz  = t_wide'($signed(cap.b_z)) - t_wide'($signed(cap.a_z));
            apx  = t_wide'($signed(s.x)) - t_wide'($signed(cap.a_x));
            apy  = t_wide'($signed(s.y)) - t_wide'($signed(cap.a_y));
            apz  = t_wide'($signed(s.z)) - t_wide'($signed(cap.a_z));
            bpx  = t_wide'($signed(s.x)) - t_wide'($signed(cap.b_x));
            bpy  = t_wide'($signed(s.y)) - t_wide'($signed(cap.b_y));
            bpz  = t_wide'($signed(s.z)) - t_wide'($signed(cap.b_z));
            rsum = t_wide'({1'b0, cap.radius}) + t_wide'({1'b0, s.radius});
            r2   = rsum * rsum;
            ab2  = abx * abx + aby * aby + abz * abz;
            d    = apx * abx + apy * aby + apz * abz;
            ap2  = apx * apx + apy * apy + apz * apz;
            bp2  = bpx * bpx + bpy * bpy + bpz * bpz;
            // zero-length segment gives d == 0, so it lands on endpoint A
            if (d <= 0)
                return ap2 <= r2;
            else if (ab2 <= d)
                return bp2 <= r2;
            else
                return ap2 * ab2 - d * d <= r2 * ab2;
        endfunction

        function void note_sphere(t_sphere s);
            hits_due.push_back(predict_hit(s));
        endfunction

        function void check_hit(logic got);
            bit want;
            if (hits_due.size() == 0) begin
                flag($sformatf("result with no transaction outstanding: hit %b", got));
                return;
            end
            want = hits_due.pop_front();
            if (got !== want)
                flag($sformatf("hit: expected %0b, actual %b", want, got));
        endfunction

        function int pending();
            return hits_due.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [W_ADDR-1:0]         paddr;
    logic [W_DATA-1:0]         pwdata;
    logic [W_DATA-1:0]         prdata;
    logic                      pready;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [W_COORD-1:0] i_sphere_x;
    logic signed [W_COORD-1:0] i_sphere_y;
    logic signed [W_COORD-1:0] i_sphere_z;
    logic        [W_RAD-1:0]   i_sphere_radius;
    logic                      i_sphere_active;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic                      o_hit;

    sphere_hit_checker sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    capsule_sphere_collision_test_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sphere_x      (i_sphere_x),
        .i_sphere_y      (i_sphere_y),
        .i_sphere_z      (i_sphere_z),
        .i_sphere_radius (i_sphere_radius),
        .i_sphere_active (i_sphere_active),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit)
    );

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_hit(o_hit);
    end

    function automatic logic signed [W_COORD-1:0] clamp_coord(longint v);
        if (v > C_MAX)
            return W_COORD'(C_MAX);
        if (v < C_MIN)
            return W_COORD'(C_MIN);
        return W_COORD'(v);
    endfunction

    // uniform over [-s, s]
    function automatic longint rand_span(longint s);
        longint unsigned r;
        r = {$urandom, $urandom};
        return longint'(r % longint'(2 * s + 1)) - s;
    endfunction

    // spread of magnitudes rather than mostly huge values
    function automatic logic [W_RAD-1:0] rand_radius();
        return W_RAD'($urandom >> $urandom_range(1, 31));
    endfunction

    function automatic t_sphere mk_sphere(longint x, longint y, longint z, longint r,
                                          bit act);
        t_sphere s;
        s.x      = clamp_coord(x);
        s.y      = clamp_coord(y);
        s.z      = clamp_coord(z);
        s.radius = W_RAD'(r);
        s.active = act;
        return s;
    endfunction

    function automatic t_capsule mk_capsule(longint ax, longint ay, longint az,
                                            longint bx, longint by, longint bz,
                                            longint r);
        t_capsule c;
        c.a_x    = clamp_coord(ax);
        c.a_y    = clamp_coord(ay);
        c.a_z    = clamp_coord(az);
        c.b_x    = clamp_coord(bx);
        c.b_y    = clamp_coord(by);
        c.b_z    = clamp_coord(bz);
        c.radius = W_RAD'(r);
        return c;
    endfunction

    function automatic t_capsule pick_capsule(int kind);
        t_capsule c;
        longint   px, py, pz;
        case (kind)
            0: c = mk_capsule(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX);
            1: c = mk_capsule(rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20),
                              rand_span(1 << 20), rand_span(1 << 20), rand_span(1 << 20),
                              $urandom_range(0, 1 << 18));
            2: begin
                c        = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            W_RAD'(0)};
                c.radius = rand_radius();
            end
            3: begin
                px = rand_span(C_MAX);
                py = rand_span(C_MAX);
                pz = rand_span(C_MAX);
                c  = mk_capsule(px, py, pz, px, py, pz, rand_radius());
            end
            default: c = mk_capsule(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0);
        endcase
        return c;
    endfunction

    // Mostly spheres placed near the capsule axis so hits and misses both occur.
    function automatic t_sphere build_sphere(t_capsule c);
        t_sphere s;
        int      sel;
        longint  k, span, ax, ay, az;
        sel      = $urandom_range(99);
        s.active = ($urandom_range(99) < 85);
        if (sel < 65) begin
            s.radius = rand_radius();
            span     = longint'(c.radius) + longint'(s.radius);
            k        = longint'($urandom_range(24)) - 2;
            ax       = longint'($signed(c.a_x));
            ay       = longint'($signed(c.a_y));
            az       = longint'($signed(c.a_z));
            s.x = clamp_coord(ax + (longint'($signed(c.b_x)) - ax) * k / 20 + rand_span(span));
            s.y = clamp_coord(ay + (longint'($signed(c.b_y)) - ay) * k / 20 + rand_span(span));
            s.z = clamp_coord(az + (longint'($signed(c.b_z)) - az) * k / 20 + rand_span(span));
        end else if (sel < 85) begin
            s.x      = $urandom;
            s.y      = $urandom;
            s.z      = $urandom;
            s.radius = W_RAD'($urandom);
        end else begin
            case ($urandom_range(3))
                0: s.x = W_COORD'(C_MIN);
                1: s.x = W_COORD'(C_MAX);
                2: s.x = '0;
                default: s.x = '1;
            endcase
            s.y      = $urandom_range(1) ? W_COORD'(C_MAX) : W_COORD'(C_MIN);
            s.z      = $urandom_range(1) ? W_COORD'(C_MIN) : '0;
            s.radius = $urandom_range(1) ? W_RAD'(R_MAX) : '0;
        end
        return s;
    endfunction

    // All drive tasks start and end on a falling edge.
    task automatic apb_write(input int idx, input logic [W_DATA-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= W_ADDR'(idx * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_read(input int idx, output logic [W_DATA-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= W_ADDR'(idx * 4);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_capsule(input t_capsule c);
        apb_write(REG_SEG_A_X, c.a_x);
        apb_write(REG_SEG_A_Y, c.a_y);
        apb_write(REG_SEG_A_Z, c.a_z);
        apb_write(REG_SEG_B_X, c.b_x);
        apb_write(REG_SEG_B_Y, c.b_y);
        apb_write(REG_SEG_B_Z, c.b_z);
        apb_write(REG_CAPSULE_RADIUS, {1'b0, c.radius});
    endtask

    task automatic verify_regs();
        logic [W_DATA-1:0] rd;
        for (int i = 0; i < N_REGS; i++) begin
            apb_read(i, rd);
            sb.check_reg(i, rd);
        end
    endtask

    // Valid stays up from one transaction to the next unless an idle cycle follows.
    task automatic send_sphere(input t_sphere s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_sphere_x      <= s.x;
        i_sphere_y      <= s.y;
        i_sphere_z      <= s.z;
        i_sphere_radius <= s.radius;
        i_sphere_active <= s.active;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sphere(s);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge i_clk);
    endtask

    task automatic set_pressure(int mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
        endcase
    endtask

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_capsule c;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_out_stall     = 1'b0;
        i_sphere_x      = '0;
        i_sphere_y      = '0;
        i_sphere_z      = '0;
        i_sphere_radius = '0;
        i_sphere_active = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unit capsule along x from 0 to 10; touching cases sit exactly on the summed radii
        set_pressure(0);
        load_capsule(mk_capsule(0, 0, 0, 10 * ONE, 0, 0, ONE));
        verify_regs();
        send_sphere(mk_sphere(5 * ONE, 3 * ONE, 0, 2 * ONE, 1));
        send_sphere(mk_sphere(5 * ONE, 3 * ONE + 1, 0, 2 * ONE, 1));
        send_sphere(mk_sphere(-3 * ONE, 0, 0, 2 * ONE, 1));
        send_sphere(mk_sphere(-3 * ONE - 1, 0, 0, 2 * ONE, 1));
        send_sphere(mk_sphere(13 * ONE, 0, 0, 2 * ONE, 1));
        send_sphere(mk_sphere(13 * ONE + 1, 0, 0, 2 * ONE, 1));
        send_sphere(mk_sphere(5 * ONE, 0, 0, 2 * ONE, 0));
        send_sphere(mk_sphere(C_MAX, C_MAX, C_MAX, R_MAX, 1));
        send_sphere(mk_sphere(C_MIN, C_MIN, C_MIN, R_MAX, 1));
        send_sphere(mk_sphere(0, 0, 0, 0, 1));
        send_sphere(mk_sphere(C_MIN, 0, 0, R_MAX, 1));
        send_sphere(mk_sphere(C_MAX, C_MIN, C_MAX, R_MAX, 0));
        send_sphere(mk_sphere(0, C_MAX, C_MIN, R_MAX, 1));

        // degenerate segment, then a write to an address with no register
        drain();
        load_capsule(mk_capsule(7 * ONE, -5 * ONE, 2 * ONE, 7 * ONE, -5 * ONE, 2 * ONE, 0));
        apb_write(UNMAPPED_REG, $urandom);
        verify_regs();
        send_sphere(mk_sphere(7 * ONE, -5 * ONE, 2 * ONE, 0, 1));
        send_sphere(mk_sphere(7 * ONE, -5 * ONE, 2 * ONE + 1, 0, 1));
        send_sphere(mk_sphere(10 * ONE, -ONE, 2 * ONE, 5 * ONE, 1));
        send_sphere(mk_sphere(10 * ONE, -ONE, 2 * ONE + 1, 5 * ONE, 1));
        send_sphere(mk_sphere(7 * ONE, -5 * ONE, 2 * ONE, R_MAX, 0));

        for (int phase = 0; phase < 10; phase++) begin
            drain();
            c = pick_capsule(phase % 5);
            load_capsule(c);
            verify_regs();
            set_pressure(phase % 4);
            repeat (40) send_sphere(build_sphere(c));
        end

        drain();
        repeat (N_STAGE + 6) @(posedge i_clk);
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
